[rtl/qb_pkg.sv]
// qb_pkg: shared types, constants and helpers of the transmit queue with backoff.
// No dependencies; the store, backoff and top-level files use it by scoped names.
package qb_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] MIN_EXP_RST = 4'd1;
    localparam logic [3:0] MAX_EXP_RST = 4'd5;
    localparam logic [8:0] WIN_SAT     = 9'd511;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_PEEK   = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_TICK   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BLOCKED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_PRIO  = 2'd0,
        CFG_MIN   = 2'd1,
        CFG_MAX   = 2'd2,
        CFG_BCAST = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       prio;
        logic [3:0] min_exp;
        logic [3:0] max_exp;
        logic       bcast;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic raise;
        logic tick;
    } t_bo_cmd;

    typedef struct packed {
        logic [7:0] handle;
        logic [1:0] cls;
        logic [7:0] limit;
    } t_entry;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] wp,
                                                    input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] s;
        if (wp >= rp)
            s = {1'b0, wp} - {1'b0, rp};
        else
            s = {1'b0, wp} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, rp};
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [3:0] count_low4(input logic [PTR_W-1:0] c);
        logic [8:0] t;
        t = 9'(c);
        return t[3:0];
    endfunction

endpackage

[rtl/qb_req_if.sv]
// qb_req_if: request channel of the transmit queue (valid/ready plus request fields).
// No dependencies.
interface qb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  packet_handle;
    logic [7:0]  class_byte;
    logic [7:0]  max_tries;
    logic        shared_link;
    logic        tx_ok;
    logic [7:0]  tries_done;
    logic [15:0] random_word;
    logic        tick_applies;

    modport source (
        output valid, req_type, packet_handle, class_byte, max_tries, shared_link,
               tx_ok, tries_done, random_word, tick_applies,
        input  ready
    );
    modport sink (
        input  valid, req_type, packet_handle, class_byte, max_tries, shared_link,
               tx_ok, tries_done, random_word, tick_applies,
        output ready
    );
endinterface

[rtl/qb_rsp_if.sv]
// qb_rsp_if: result channel of the transmit queue (valid/ready plus result fields).
// No dependencies.
interface qb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] head_handle;
    logic       still_queued;
    logic [3:0] queue_count;

    modport source (
        output valid, status, head_handle, still_queued, queue_count,
        input  ready
    );
    modport sink (
        input  valid, status, head_handle, still_queued, queue_count,
        output ready
    );
endinterface

[rtl/qb_store.sv]
// qb_store: ring entry memory, one write and one registered read port.
// Depends on qb_pkg.
module qb_store (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [qb_pkg::PTR_W-1:0] i_waddr,
    input  qb_pkg::t_entry           i_wdata,
    input  logic [qb_pkg::PTR_W-1:0] i_raddr,
    output qb_pkg::t_entry           o_rdata
);

    qb_pkg::t_entry mem [qb_pkg::QUEUE_DEPTH];
    qb_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/qb_backoff.sv]
// qb_backoff: CSMA backoff exponent and window registers with their update logic.
// Depends on qb_pkg.
module qb_backoff (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qb_pkg::t_cfg    i_cfg,
    input  qb_pkg::t_bo_cmd i_cmd,
    input  logic [15:0]     i_rnd,
    output logic            o_win_nz
);

    logic [3:0] r_exp, n_exp;
    logic [8:0] r_win, n_win;
    logic [4:0] e_inc;
    logic [3:0] e_sat;
    logic [9:0] rnd_sh;
    logic [9:0] masked;
    logic [10:0] sum;

    always_comb begin
        e_inc = {1'b0, r_exp} + 5'd1;
        e_sat = (e_inc > {1'b0, i_cfg.max_exp}) ? i_cfg.max_exp : e_inc[3:0];
        rnd_sh = i_rnd[15:6];
        for (int i = 0; i < 10; i++)
            masked[i] = rnd_sh[i] & (4'(i) < e_sat);
        sum = {1'b0, masked} + 11'd1;

        n_exp = r_exp;
        n_win = r_win;
        if (i_cmd.clear) begin
            n_exp = i_cfg.min_exp;
            n_win = '0;
        end else if (i_cmd.raise) begin
            n_exp = e_sat;
            n_win = (sum > 11'(qb_pkg::WIN_SAT)) ? qb_pkg::WIN_SAT : sum[8:0];
        end else if (i_cmd.tick && r_win != '0) begin
            n_win = r_win - 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= qb_pkg::MIN_EXP_RST;
            r_win <= '0;
        end else begin
            r_exp <= n_exp;
            r_win <= n_win;
        end
    end

    assign o_win_nz = (r_win != '0);

endmodule

[rtl/priority_tx_queue_with_csma_backoff.sv]
// priority_tx_queue_with_csma_backoff: top level, request sequencer and pointers.
// Depends on qb_pkg, qb_req_if, qb_rsp_if, qb_store, qb_backoff.
//
//   channel   dir  handshake             contents
//   i_req     in   valid/ready           one request: enqueue, peek, report, tick
//   o_rsp     out  valid/ready           status, head handle, still queued, count
//   i_cfg_*   in   write enable only     register index and 4-bit data
//
// One request at a time; a request is taken only while the sequencer is idle.
// Peek, report, tick and FIFO enqueue pass from accept through the execute state to the done state.
// A priority enqueue onto a non-empty ring adds an insert state and, per entry it
// compares, a memory read state and then a compare-and-move state, since the store
// read port is registered.
// Sync reset empties the ring at once; no clearing pass. A stalled result
// holds the sequencer in its final state until taken.
module priority_tx_queue_with_csma_backoff (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    qb_req_if.sink     i_req,
    qb_rsp_if.source   o_rsp
);

    localparam int PW = qb_pkg::PTR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_CMP,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        qb_pkg::t_req_type rtype;
        logic [7:0]        handle;
        logic [1:0]        cls;
        logic [7:0]        limit;
        logic              shared;
        logic              ok;
        logic [7:0]        tries;
        logic [15:0]       rnd;
        logic              applies;
    } t_req;

    t_state          r_state, n_state;
    qb_pkg::t_cfg    r_cfg, n_cfg;
    t_req            r_req, n_req;
    logic [PW-1:0]   r_rp, n_rp, r_wp, n_wp, r_pos, n_pos, r_left, n_left;
    qb_pkg::t_status r_st, n_st;
    logic [7:0]      r_head, n_head;
    logic            r_still, n_still;
    logic            r_rsp_valid, n_rsp_valid;
    qb_pkg::t_status r_o_st, n_o_st;
    logic [7:0]      r_o_head, n_o_head;
    logic            r_o_still, n_o_still;
    logic [3:0]      r_o_cnt, n_o_cnt;

    logic            accept;
    logic [PW-1:0]   count;
    logic            mem_we;
    logic [PW-1:0]   mem_waddr, mem_raddr;
    qb_pkg::t_entry  mem_wdata, mem_rdata, new_entry;
    qb_pkg::t_bo_cmd bo_cmd;
    logic            win_nz;

    qb_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    qb_backoff u_backoff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (bo_cmd),
        .i_rnd    (r_req.rnd),
        .o_win_nz (win_nz)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign accept             = i_req.valid && (r_state == S_IDLE);
    assign count              = qb_pkg::ring_count(r_wp, r_rp);
    assign new_entry.handle   = r_req.handle;
    assign new_entry.cls      = r_req.cls;
    assign new_entry.limit    = r_req.limit;
    assign mem_raddr          = (r_state == S_SH_RD) ? qb_pkg::ptr_prev(r_pos) : r_rp;

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_req       = r_req;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_pos       = r_pos;
        n_left      = r_left;
        n_st        = r_st;
        n_head      = r_head;
        n_still     = r_still;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_o_st      = r_o_st;
        n_o_head    = r_o_head;
        n_o_still   = r_o_still;
        n_o_cnt     = r_o_cnt;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = new_entry;
        bo_cmd      = '0;

        if (i_cfg_we) begin
            unique case (qb_pkg::t_cfg_idx'(i_cfg_index))
                qb_pkg::CFG_PRIO:  n_cfg.prio    = i_cfg_data[0];
                qb_pkg::CFG_MIN:   n_cfg.min_exp = i_cfg_data;
                qb_pkg::CFG_MAX:   n_cfg.max_exp = i_cfg_data;
                qb_pkg::CFG_BCAST: n_cfg.bcast   = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req.rtype   = qb_pkg::t_req_type'(i_req.req_type);
                    n_req.handle  = i_req.packet_handle;
                    n_req.cls     = (i_req.class_byte > 8'd2) ? 2'd0 : i_req.class_byte[1:0];
                    n_req.limit   = i_req.max_tries;
                    n_req.shared  = i_req.shared_link;
                    n_req.ok      = i_req.tx_ok;
                    n_req.tries   = i_req.tries_done;
                    n_req.rnd     = i_req.random_word;
                    n_req.applies = i_req.tick_applies;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_st    = qb_pkg::ST_DONE;
                n_head  = '0;
                n_still = 1'b0;
                n_state = S_DONE;
                unique case (r_req.rtype)
                    qb_pkg::REQ_ENQ: begin
                        if (count == PW'(qb_pkg::QUEUE_DEPTH - 1)) begin
                            n_st = qb_pkg::ST_FULL;
                        end else if (r_cfg.prio && count != '0) begin
                            n_pos   = r_wp;
                            n_left  = count;
                            n_state = S_SH_RD;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wp;
                            n_wp      = qb_pkg::ptr_next(r_wp);
                        end
                    end
                    qb_pkg::REQ_PEEK: begin
                        if (count == '0)
                            n_st = qb_pkg::ST_EMPTY;
                        else if (r_req.shared && win_nz)
                            n_st = qb_pkg::ST_BLOCKED;
                        else
                            n_head = mem_rdata.handle;
                    end
                    qb_pkg::REQ_REPORT: begin
                        if (count == '0) begin
                            n_st = qb_pkg::ST_EMPTY;
                        end else if (r_req.ok) begin
                            n_rp         = qb_pkg::ptr_next(r_rp);
                            bo_cmd.clear = !r_cfg.bcast &&
                                           (r_req.shared || count == PW'(1));
                        end else begin
                            if (r_req.tries >= mem_rdata.limit)
                                n_rp = qb_pkg::ptr_next(r_rp);
                            else
                                n_still = 1'b1;
                            bo_cmd.raise = !r_cfg.bcast && r_req.shared;
                        end
                    end
                    qb_pkg::REQ_TICK: begin
                        bo_cmd.tick = r_req.applies;
                    end
                    default: ;
                endcase
            end
            S_SH_RD: begin
                n_state = S_SH_CMP;
            end
            S_SH_CMP: begin
                if (r_req.cls <= mem_rdata.cls) begin
                    n_state = S_INSERT;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = mem_rdata;
                    n_pos     = qb_pkg::ptr_prev(r_pos);
                    n_left    = r_left - PW'(1);
                    n_state   = (r_left == PW'(1)) ? S_INSERT : S_SH_RD;
                end
            end
            S_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                n_wp      = qb_pkg::ptr_next(r_wp);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1;
                    n_o_st      = r_st;
                    n_o_head    = r_head;
                    n_o_still   = r_still;
                    n_o_cnt     = qb_pkg::count_low4(count);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= '{prio: 1'b0, min_exp: qb_pkg::MIN_EXP_RST,
                             max_exp: qb_pkg::MAX_EXP_RST, bcast: 1'b0};
            r_rp        <= '0;
            r_wp        <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_rsp_valid <= n_rsp_valid;
        end
        r_req     <= n_req;
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_st      <= n_st;
        r_head    <= n_head;
        r_still   <= n_still;
        r_o_st    <= n_o_st;
        r_o_head  <= n_o_head;
        r_o_still <= n_o_still;
        r_o_cnt   <= n_o_cnt;
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_o_st;
    assign o_rsp.head_handle  = r_o_head;
    assign o_rsp.still_queued = r_o_still;
    assign o_rsp.queue_count  = r_o_cnt;

endmodule
